/* sv/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg - shared types and constants for the bitmap frame allocator
// Command and status codes, controller states and frame geometry.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Frame geometry: 4 KiB frames
  localparam int unsigned FRAME_SHIFT = 12;
  localparam logic [11:0] OFFSET_MASK = 12'hFFF;

  // Commands carried on the input beat
  typedef enum logic [1:0] {
    CMD_ALLOC_ANY   = 2'd0,
    CMD_ALLOC_AT    = 2'd1,
    CMD_FREE_AT     = 2'd2,
    CMD_FREE_REGION = 2'd3
  } bfa_cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_MISALIGN = 2'd2,
    STAT_BEYOND   = 2'd3
  } bfa_status_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_DIV,
    ST_RD,
    ST_MOD,
    ST_RESP
  } bfa_state_e;

endpackage

/* sv/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator - page frame allocator over a free bitmap
// One free bit per 4 KiB frame, held in a single-port-read synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (s_axis): tuser = command, tdata = {region_size, addr}.
//   Output beat (m_axis): tdata = {status, frame_addr}; one beat per command.
//   After reset a clearing pass writes every bitmap word to zero (all frames
//   allocated); during the pass s_axis_tready_o is low.
//   Commands run one at a time; each bitmap word is read in ST_RD, then
//   modified and written back in ST_MOD (the RAM read port is registered).
//   Steps per command, after accept and decode (ST_DEC):
//     allocate any : reads words upward from the lowest word that may hold a
//                    free frame (a hint register tracks it) and clears a bit
//     alloc/free at: split index by WORD_BITS (ST_DIV), one read-modify-write
//     free region  : split index (ST_DIV), read-modify-write per word touched
//     rejected or empty commands: decode only, then the result
//   A finished result sits in an output register; the next command is taken
//   while it waits. If the receiver stalls, the following result is held until
//   the output register frees up, and input acceptance stops meanwhile.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int unsigned NUM_FRAMES = 32768,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] addr, [63:32] region_size
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] frame_addr, [33:32] status, zero pad
);

  localparam int unsigned NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned NWW  = $clog2(NUM_WORDS + 1);
  localparam int unsigned FI_W = $clog2(NUM_FRAMES);
  localparam int unsigned FE_W = $clog2(NUM_FRAMES + 1);
  localparam int unsigned BS_W = $clog2(NUM_FRAMES + 2 * WORD_BITS);
  localparam int unsigned BI_W = $clog2(WORD_BITS);
  localparam int unsigned RW   = BI_W + 1;
  localparam int unsigned DC_W = 1;
  // Reciprocal of WORD_BITS, exact for every frame index below 2**FI_W
  localparam int unsigned     QSH   = FI_W + BI_W;
  localparam int unsigned     PW    = 2 * FI_W + 2;
  localparam longint unsigned RECIP = ((64'd1 << QSH) + 64'(WORD_BITS) - 64'd1) /
                                      64'(WORD_BITS);

  // Control registers
  bfa_pkg::bfa_state_e state_q, state_d;
  logic [NWW-1:0]      clr_cnt_q, clr_cnt_d;
  logic [DC_W-1:0]     div_cnt_q, div_cnt_d;
  logic [NWW-1:0]      hint_q, hint_d;
  logic                out_valid_q, out_valid_d;

  // Payload registers
  bfa_pkg::bfa_cmd_e    cmd_q, cmd_d;
  logic [31:0]          addr_q, addr_d;
  logic [31:0]          size_q, size_d;
  logic [FE_W-1:0]      end_q, end_d;
  logic [FI_W-1:0]      num_q, num_d;
  logic [FI_W-1:0]      idx_q, idx_d;
  logic [NWW-1:0]       word_q, word_d;
  logic [BS_W-1:0]      base_q, base_d;
  logic [BI_W-1:0]      lo_q, lo_d;
  logic [BS_W-1:0]      hint_base_q, hint_base_d;
  logic [31:0]          res_addr_q, res_addr_d;
  bfa_pkg::bfa_status_e res_st_q, res_st_d;
  logic [31:0]          out_addr_q, out_addr_d;
  bfa_pkg::bfa_status_e out_st_q, out_st_d;

  // Bitmap RAM
  logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 mem_re, mem_we;
  logic [AW-1:0]        mem_raddr, mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // Decode helpers
  logic [32:0]     start_sum, end_sum;
  logic [20:0]     start_fr, end_fr;
  logic [FE_W-1:0] end_clamp;
  logic [19:0]     page_idx;
  logic            misaligned, beyond, region_empty;

  // Index split helpers
  logic [PW-1:0]   quo_prod;
  logic [FI_W-1:0] num_nx;
  logic [BS_W-1:0] base_nx;
  logic [BI_W-1:0] lo_nx;

  // Word modify helpers
  logic [BI_W-1:0]      lsb;
  logic                 found;
  logic [BS_W-1:0]      fidx, span, next_base;
  logic [RW-1:0]        lim;
  logic [WORD_BITS-1:0] one_hot, region_mask;

  assign s_axis_tready_o = (state_q == bfa_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_st_q, out_addr_q};

  // Region bounds and single-frame checks
  always_comb begin
    start_sum  = {1'b0, addr_q} + 33'(bfa_pkg::OFFSET_MASK);
    end_sum    = {1'b0, addr_q} + {1'b0, size_q};
    start_fr   = start_sum[32:12];
    end_fr     = end_sum[32:12];
    end_clamp  = (end_fr > 21'(NUM_FRAMES)) ? FE_W'(NUM_FRAMES) : FE_W'(end_fr);
    region_empty = (start_fr >= 21'(end_clamp));
    page_idx   = addr_q[31:12];
    misaligned = ((addr_q[11:0] & bfa_pkg::OFFSET_MASK) != 12'd0);
    beyond     = ({1'b0, page_idx} >= 21'(NUM_FRAMES));
  end

  // Divide by WORD_BITS: quotient by reciprocal multiply, then base and offset
  always_comb begin
    quo_prod = PW'(num_q) * PW'(RECIP);
    num_nx   = FI_W'(quo_prod >> QSH);
    base_nx  = BS_W'(num_q) * BS_W'(WORD_BITS);
    lo_nx    = BI_W'(BS_W'(idx_q) - base_nx);
  end

  // Word modify: lowest free bit, one-hot bit, region mask
  always_comb begin
    lsb = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (rd_data_q[b]) lsb = BI_W'(b);
    end
    found     = |rd_data_q;
    fidx      = base_q + BS_W'(lsb);
    one_hot   = WORD_BITS'(1) << lo_q;
    span      = BS_W'(end_q) - base_q;
    lim       = (span >= BS_W'(WORD_BITS)) ? RW'(WORD_BITS) : RW'(span);
    next_base = base_q + BS_W'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      region_mask[b] = (RW'(b) >= RW'(lo_q)) && (RW'(b) < lim);
    end
  end

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    div_cnt_d   = div_cnt_q;
    hint_d      = hint_q;
    hint_base_d = hint_base_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    size_d      = size_q;
    end_d       = end_q;
    num_d       = num_q;
    idx_d       = idx_q;
    word_d      = word_q;
    base_d      = base_q;
    lo_d        = lo_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = word_q[AW-1:0];
    mem_waddr   = word_q[AW-1:0];
    mem_wdata   = rd_data_q;

    unique case (state_q)
      // Zero the bitmap after reset
      bfa_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q[AW-1:0];
        mem_wdata = '0;
        if (clr_cnt_q == NWW'(NUM_WORDS - 1)) begin
          state_d = bfa_pkg::ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + NWW'(1);
        end
      end

      bfa_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = bfa_pkg::bfa_cmd_e'(s_axis_tuser_i);
          addr_d  = s_axis_tdata_i[31:0];
          size_d  = s_axis_tdata_i[63:32];
          state_d = bfa_pkg::ST_DEC;
        end
      end

      bfa_pkg::ST_DEC: begin
        res_addr_d = '0;
        res_st_d   = bfa_pkg::STAT_OK;
        div_cnt_d  = DC_W'(1);
        unique case (cmd_q)
          bfa_pkg::CMD_ALLOC_ANY: begin
            if (hint_q == NWW'(NUM_WORDS)) begin
              res_st_d = bfa_pkg::STAT_NO_FREE;
              state_d  = bfa_pkg::ST_RESP;
            end else begin
              word_d  = hint_q;
              base_d  = hint_base_q;
              state_d = bfa_pkg::ST_RD;
            end
          end
          bfa_pkg::CMD_ALLOC_AT, bfa_pkg::CMD_FREE_AT: begin
            if (misaligned) begin
              res_st_d = bfa_pkg::STAT_MISALIGN;
              state_d  = bfa_pkg::ST_RESP;
            end else if (beyond) begin
              res_st_d = bfa_pkg::STAT_BEYOND;
              state_d  = bfa_pkg::ST_RESP;
            end else begin
              num_d   = FI_W'(page_idx);
              idx_d   = FI_W'(page_idx);
              state_d = bfa_pkg::ST_DIV;
            end
          end
          bfa_pkg::CMD_FREE_REGION: begin
            if (region_empty) begin
              state_d = bfa_pkg::ST_RESP;
            end else begin
              num_d   = FI_W'(start_fr);
              idx_d   = FI_W'(start_fr);
              end_d   = end_clamp;
              state_d = bfa_pkg::ST_DIV;
            end
          end
          default: state_d = bfa_pkg::ST_RESP;
        endcase
      end

      // Split frame index into word and bit
      bfa_pkg::ST_DIV: begin
        div_cnt_d = div_cnt_q - DC_W'(1);
        if (div_cnt_q != '0) begin
          num_d = num_nx;
        end else begin
          word_d  = NWW'(num_q);
          lo_d    = lo_nx;
          base_d  = base_nx;
          state_d = bfa_pkg::ST_RD;
          // freed word may lie below the lowest-free hint
          if (cmd_q != bfa_pkg::CMD_ALLOC_AT && NWW'(num_q) < hint_q) begin
            hint_d      = NWW'(num_q);
            hint_base_d = base_nx;
          end
        end
      end

      bfa_pkg::ST_RD: begin
        mem_re  = 1'b1;
        state_d = bfa_pkg::ST_MOD;
      end

      // Modify and write back the word read last cycle unless a scan finds it full
      bfa_pkg::ST_MOD: begin
        unique case (cmd_q)
          bfa_pkg::CMD_ALLOC_ANY: begin
            if (found) begin
              mem_we      = 1'b1;
              mem_wdata   = rd_data_q & ~(WORD_BITS'(1) << lsb);
              res_addr_d  = 32'(fidx) << bfa_pkg::FRAME_SHIFT;
              hint_d      = word_q;
              hint_base_d = base_q;
              state_d     = bfa_pkg::ST_RESP;
            end else if (word_q == NWW'(NUM_WORDS - 1)) begin
              res_st_d = bfa_pkg::STAT_NO_FREE;
              hint_d   = NWW'(NUM_WORDS);
              state_d  = bfa_pkg::ST_RESP;
            end else begin
              word_d  = word_q + NWW'(1);
              base_d  = next_base;
              state_d = bfa_pkg::ST_RD;
            end
          end
          bfa_pkg::CMD_ALLOC_AT: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_q & ~one_hot;
            state_d   = bfa_pkg::ST_RESP;
          end
          bfa_pkg::CMD_FREE_AT: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_q | one_hot;
            state_d   = bfa_pkg::ST_RESP;
          end
          bfa_pkg::CMD_FREE_REGION: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_q | region_mask;
            if (next_base >= BS_W'(end_q)) begin
              state_d = bfa_pkg::ST_RESP;
            end else begin
              word_d  = word_q + NWW'(1);
              base_d  = next_base;
              lo_d    = '0;
              state_d = bfa_pkg::ST_RD;
            end
          end
          default: state_d = bfa_pkg::ST_RESP;
        endcase
      end

      // Hand the result to the output register once it is free
      bfa_pkg::ST_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_st_d    = res_st_q;
          state_d     = bfa_pkg::ST_IDLE;
        end
      end

      default: state_d = bfa_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfa_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      hint_q      <= NWW'(NUM_WORDS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      div_cnt_q   <= div_cnt_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    addr_q      <= addr_d;
    size_q      <= size_d;
    end_q       <= end_d;
    num_q       <= num_d;
    idx_q       <= idx_d;
    word_q      <= word_d;
    base_q      <= base_d;
    lo_q        <= lo_d;
    hint_base_q <= hint_base_d;
    res_addr_q  <= res_addr_d;
    res_st_q    <= res_st_d;
    out_addr_q  <= out_addr_d;
    out_st_q    <= out_st_d;
  end

  // Bitmap RAM: one write port, one registered read port.
  // Reads and writes fall in separate states, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) bitmap_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_data_q <= bitmap_mem[mem_raddr];
  end

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfa_pkg::ST_CLEAR) |-> !s_axis_tready_o)
    else $error("input accepted during bitmap clearing pass");

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("bitmap read and write in the same cycle");

  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q != bfa_pkg::STAT_OK) |-> (out_addr_q == 32'd0))
    else $error("failed command returned a nonzero frame address");

  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= NWW'(NUM_WORDS))
    else $error("free-word hint out of range");

  a_accept_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == bfa_pkg::ST_DEC))
    else $error("accepted beat not decoded");

endmodule
